// ===== design/shp_pkg.sv =====
`default_nettype none
package shp_pkg;

  localparam int POSITION_WIDTH_DEF = 25;
  localparam int TIMER_WIDTH_DEF    = 16;
  localparam int CFG_W              = 16;
  localparam int DEG_W              = 16;

  localparam logic [1:0] OP_TICK       = 2'd0;
  localparam logic [1:0] OP_SET_TARGET = 2'd1;
  localparam logic [1:0] OP_ENERGIZE   = 2'd2;

  localparam logic REG_STEP_DELAY    = 1'b0;
  localparam logic REG_STEPS_PER_DEG = 1'b1;

  localparam logic [CFG_W-1:0] STEP_DELAY_RST    = 16'd1000;
  localparam logic [CFG_W-1:0] STEPS_PER_DEG_RST = 16'd256;

  localparam logic [2:0] PHASE_LAST = 3'd7;

  typedef struct packed {
    logic [CFG_W-1:0] step_delay;
    logic [CFG_W-1:0] steps_per_deg;
  } cfg_t;

  // Half-step coil sequence, bit k drives coil k
  function automatic logic [3:0] phase_coils(input logic [2:0] phase);
    logic [3:0] pat;
    case (phase)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h5;
      3'd2:    pat = 4'h4;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h2;
      3'd5:    pat = 4'hA;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

// ===== design/shp_regs.sv =====
`default_nettype none
module shp_regs
  import shp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_delay    <= STEP_DELAY_RST;
      cfg.steps_per_deg <= STEPS_PER_DEG_RST;
    end else if (wr_en) begin
      if (reg_sel == REG_STEP_DELAY) begin
        cfg.step_delay <= pwdata[CFG_W-1:0];
      end else begin
        cfg.steps_per_deg <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == REG_STEPS_PER_DEG) begin
      prdata = 32'(cfg.steps_per_deg);
    end else begin
      prdata = 32'(cfg.step_delay);
    end
  end

endmodule
`default_nettype wire

// ===== design/shp_core.sv =====
`default_nettype none
module shp_core
  import shp_pkg::*;
#(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
  parameter int TIMER_WIDTH    = TIMER_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             en,
  input  wire logic [1:0]                       op,
  input  wire logic signed [DEG_W-1:0]          degrees,
  input  wire cfg_t                             cfg,
  output logic [3:0]                            coil_next,
  output logic signed [POSITION_WIDTH-1:0]      pos_next,
  output logic                                  busy_next
);

  localparam int PROD_W = DEG_W + CFG_W + 1;
  localparam int QUOT_W = PROD_W - 8;
  localparam int CW     = ((POSITION_WIDTH > QUOT_W) ? POSITION_WIDTH : QUOT_W) + 1;
  localparam int TCMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
  localparam logic signed [CW-1:0] PMAX = (CW'(1) <<< (POSITION_WIDTH - 1)) - CW'(1);
  localparam logic signed [CW-1:0] PMIN = -PMAX - CW'(1);

  logic [2:0]                       phase, phase_next;
  logic signed [POSITION_WIDTH-1:0] cur;
  logic signed [POSITION_WIDTH-1:0] tgt, tgt_next;
  logic [TIMER_WIDTH-1:0]           ticks, ticks_next, tick_inc;
  logic [3:0]                       coil;

  logic signed [PROD_W-1:0] prod, prod_adj;
  logic signed [QUOT_W-1:0] quot;
  logic signed [CW-1:0]     quot_ext;
  logic [POSITION_WIDTH-1:0] tgt_sat;
  logic                      step_due;
  logic [2:0]                phase_step;

  // Degrees to half steps, truncate toward zero, saturate
  assign prod     = degrees * $signed({1'b0, cfg.steps_per_deg});
  assign prod_adj = prod + (prod[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
  assign quot     = prod_adj[PROD_W-1:8];
  assign quot_ext = CW'(quot);

  always_comb begin
    if (quot_ext > PMAX) begin
      tgt_sat = PMAX[POSITION_WIDTH-1:0];
    end else if (quot_ext < PMIN) begin
      tgt_sat = PMIN[POSITION_WIDTH-1:0];
    end else begin
      tgt_sat = quot_ext[POSITION_WIDTH-1:0];
    end
  end

  assign tick_inc = (ticks == '1) ? ticks : ticks + 1'b1;
  assign step_due = (cur != tgt) &&
                    (TCMP_W'(tick_inc) >= TCMP_W'(cfg.step_delay));
  assign phase_step = (tgt > cur) ? phase + 3'd1 : phase + PHASE_LAST;

  always_comb begin
    phase_next = phase;
    pos_next   = cur;
    tgt_next   = tgt;
    ticks_next = ticks;
    coil_next  = coil;
    case (op)
      OP_TICK: begin
        ticks_next = tick_inc;
        if (step_due) begin
          ticks_next = '0;
          phase_next = phase_step;
          pos_next   = (tgt > cur) ? cur + 1'b1 : cur - 1'b1;
          coil_next  = phase_coils(phase_step);
        end
      end
      OP_SET_TARGET: begin
        tgt_next   = tgt_sat;
        ticks_next = '0;
      end
      OP_ENERGIZE: begin
        coil_next = phase_coils(phase);
      end
      default: begin
      end
    endcase
  end

  assign busy_next = (pos_next != tgt_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      cur   <= '0;
      tgt   <= '0;
      ticks <= '0;
      coil  <= '0;
    end else if (en) begin
      phase <= phase_next;
      cur   <= pos_next;
      tgt   <= tgt_next;
      ticks <= ticks_next;
      coil  <= coil_next;
    end
  end

  // A move always restarts the step timer
  a_move_clears_timer: assert property (@(posedge clk) disable iff (rst)
    (cur != $past(cur)) |-> (ticks == '0))
    else $error("position moved without clearing the step timer");

  // Position moves by one half step at most
  a_single_step: assert property (@(posedge clk) disable iff (rst)
    (cur != $past(cur)) |->
      ((cur == $past(cur) + 1'b1) || (cur == $past(cur) - 1'b1)))
    else $error("position jumped by more than one half step");

  // Phase advances with each forward move
  a_phase_follows: assert property (@(posedge clk) disable iff (rst)
    (cur == $past(cur) + 1'b1 && cur != $past(cur)) |->
      (phase == $past(phase) + 3'd1))
    else $error("phase did not advance with a forward step");

  // Coils change only on a tick step or an energize
  a_coil_source: assert property (@(posedge clk) disable iff (rst)
    (coil != $past(coil)) |-> (coil == phase_coils(phase)))
    else $error("coil pattern does not match the current phase");

endmodule
`default_nettype wire

// ===== design/stepper_half_step_positioner.sv =====
// Half-step stepper positioner.
// Input stream: s_axis_tuser carries the operation (tick, set target, energize),
// s_axis_tdata carries the signed target angle in whole degrees. Every accepted
// beat yields exactly one output beat on m_axis with the coil pattern, the
// position in half steps and the busy flag, all taken after that item's update.
// Configuration (step delay in ticks, steps per degree in Q8.8) is written over
// the APB port at byte addresses 0 and 4, by the user while the stream is idle;
// the block does not enforce this. Items pass the input register, then the result
// register that the state update feeds. Throughput: one item per cycle while the
// receiver accepts results; the state update is a single pass of compare,
// increment, phase lookup and one 16x17 multiply for the target conversion.
// If the receiver stalls, the result register holds its beat and the input
// register still takes one more beat; s_axis_tready drops only when both hold.
// Reset clears position, target, phase, step timer and coils (all off) and
// restores the register defaults: step delay 1000, 256 in Q8.8.
`default_nettype none
module stepper_half_step_positioner
  import shp_pkg::*;
#(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
  parameter int TIMER_WIDTH    = TIMER_WIDTH_DEF,
  localparam int OUT_W   = 4 + POSITION_WIDTH + 1,
  localparam int TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [15:0]        s_axis_tdata,   // [15:0] degrees
  input  wire logic [1:0]         s_axis_tuser,   // [1:0] operation
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [TDATA_W-1:0]      m_axis_tdata,   // [3:0] coil_pattern, position, busy_res
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t cfg;

  logic                      s1_valid;
  logic [1:0]                s1_op;
  logic signed [DEG_W-1:0]   s1_deg;
  logic                      adv;

  logic [3:0]                       coil_next;
  logic signed [POSITION_WIDTH-1:0] pos_next;
  logic                             busy_next;

  logic [3:0]                       out_coil;
  logic [POSITION_WIDTH-1:0]        out_pos;
  logic                             out_busy;

  assign adv           = s1_valid & (~m_axis_tvalid | m_axis_tready);
  assign s_axis_tready = ~s1_valid | adv;

  shp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  shp_core #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .TIMER_WIDTH    (TIMER_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .op        (s1_op),
    .degrees   (s1_deg),
    .cfg       (cfg),
    .coil_next (coil_next),
    .pos_next  (pos_next),
    .busy_next (busy_next)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_op  <= s_axis_tuser;
      s1_deg <= $signed(s_axis_tdata);
    end
  end

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_coil <= coil_next;
      out_pos  <= pos_next;
      out_busy <= busy_next;
    end
  end

  assign m_axis_tdata = TDATA_W'({out_busy, out_pos, out_coil});

endmodule
`default_nettype wire

// ===== bench/stepper_half_step_positioner_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module stepper_half_step_positioner_tb;
  import shp_pkg::*;

  localparam int POS_W = POSITION_WIDTH_DEF;
  localparam int TMR_W = TIMER_WIDTH_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam longint POS_MAX = (64'sd1 <<< (POS_W - 1)) - 1;
  localparam longint POS_MIN = -POS_MAX - 1;
  // phase 0 in the low nibble
  localparam logic [31:0] HALF_STEP_SEQ = {4'h9, 4'h8, 4'hA, 4'h2, 4'h6, 4'h4, 4'h5, 4'h1};
  localparam int LONG_HOLD_CYCLES = 250;
  localparam int WATCHDOG_LIMIT   = 3000;

  typedef struct packed {
    logic [3:0]              coils;
    logic signed [POS_W-1:0] position;
    logic                    busy;
  } motion_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] degrees
  logic [1:0]  s_axis_tuser = '0;   // [1:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [3:0] coil_pattern, [28:4] position, [29] busy_res
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  stepper_half_step_positioner u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Motor model state
  logic [2:0]              phase_q = '0;
  logic signed [POS_W-1:0] pos_q = '0;
  logic signed [POS_W-1:0] target_q = '0;
  logic [TMR_W-1:0]        tick_count_q = '0;
  logic [3:0]              coils_q = '0;
  logic [CFG_W-1:0]        step_delay_q = STEP_DELAY_RST;
  logic [CFG_W-1:0]        steps_per_deg_q = STEPS_PER_DEG_RST;

  motion_state_t expected_motion[$];
  int  err_count = 0;
  int  items_sent = 0;
  bit  tx_gaps_en = 1'b0;
  bit  rx_stall_en = 1'b0;
  int  long_hold_requests = 0;
  int  long_hold_served = 0;
  int  rx_hold_left = 0;
  int  idle_cycles = 0;

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [3:0] coils_of(input logic [2:0] ph);
    return HALF_STEP_SEQ[{ph, 2'b00} +: 4];
  endfunction

  task automatic advance_motor_model(input logic [1:0] op, input logic [15:0] deg);
    longint prod;
    longint quot;
    motion_state_t st;
    case (op)
      OP_TICK: begin
        if (tick_count_q != '1) tick_count_q = tick_count_q + 1'b1;
        if (pos_q != target_q && tick_count_q >= step_delay_q) begin
          tick_count_q = '0;
          if (target_q > pos_q) begin
            pos_q   = pos_q + 1;
            phase_q = phase_q + 3'd1;
          end else begin
            pos_q   = pos_q - 1;
            phase_q = phase_q - 3'd1;
          end
          coils_q = coils_of(phase_q);
        end
      end
      OP_SET_TARGET: begin
        prod = longint'($signed(deg)) * longint'(steps_per_deg_q);
        quot = prod / 256;  // truncates toward zero
        if (quot > POS_MAX) quot = POS_MAX;
        if (quot < POS_MIN) quot = POS_MIN;
        target_q     = quot[POS_W-1:0];
        tick_count_q = '0;
      end
      OP_ENERGIZE: coils_q = coils_of(phase_q);
      default: ;
    endcase
    st.coils    = coils_q;
    st.position = pos_q;
    st.busy     = (pos_q != target_q);
    expected_motion.push_back(st);
  endtask

  task automatic send_item(input logic [1:0] op, input logic [15:0] deg);
    int gap;
    gap = 0;
    if (tx_gaps_en && $urandom_range(0, 99) < 35) gap = stall_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= deg;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    advance_motor_model(op, deg);
    items_sent++;
  endtask

  task automatic drain_stream();
    s_axis_tvalid <= 1'b0;
    while (expected_motion.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_STEP_DELAY) step_delay_q = value;
    else steps_per_deg_q = value;
  endtask

  task automatic configure(input logic [CFG_W-1:0] delay, input logic [CFG_W-1:0] spd);
    drain_stream();
    write_register(REG_STEP_DELAY, delay);
    write_register(REG_STEPS_PER_DEG, spd);
  endtask

  // Receiver: random stalls plus the requested long hold
  always @(posedge clk) begin
    if (long_hold_served != long_hold_requests) begin
      long_hold_served = long_hold_requests;
      rx_hold_left = LONG_HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_stall_en && $urandom_range(0, 99) < 20) begin
      rx_hold_left = stall_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    err_count++;
    if (err_count <= 10)
      $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    motion_state_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_motion.size() == 0) begin
        report_mismatch("unexpected beat", 32'h0, m_axis_tdata);
      end else begin
        want = expected_motion.pop_front();
        if (m_axis_tdata[3:0] !== want.coils)
          report_mismatch("coil_pattern", 32'(want.coils), 32'(m_axis_tdata[3:0]));
        if (m_axis_tdata[28:4] !== want.position)
          report_mismatch("position", 32'(want.position), 32'(m_axis_tdata[28:4]));
        if (m_axis_tdata[29] !== want.busy)
          report_mismatch("busy_res", 32'(want.busy), 32'(m_axis_tdata[29]));
        if (m_axis_tdata[31:30] !== 2'b00)
          report_mismatch("pad bits", 32'h0, 32'(m_axis_tdata[31:30]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL stepper_half_step_positioner");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_power_on_defaults();
    send_item(OP_TICK, 16'h0000);
    send_item(OP_UNUSED, 16'hFFFF);
    send_item(OP_ENERGIZE, 16'h0000);
    send_item(OP_SET_TARGET, 16'h7FFF);
    send_item(OP_TICK, 16'h5A5A);
    send_item(OP_TICK, 16'hA5A5);
    send_item(OP_SET_TARGET, 16'h8000);
    send_item(OP_SET_TARGET, 16'h0000);
  endtask

  // Zero delay steps on every tick; walk back through phase 0 to wrap
  task automatic test_half_step_walk();
    configure(16'd0, 16'd256);
    send_item(OP_SET_TARGET, 16'd3);
    repeat (4) send_item(OP_TICK, 16'h0000);
    send_item(OP_SET_TARGET, 16'hFFFE);
    repeat (6) send_item(OP_TICK, 16'h0000);
    send_item(OP_ENERGIZE, 16'h0000);
  endtask

  task automatic test_angle_conversion();
    configure(16'd1, 16'hFFFF);
    send_item(OP_SET_TARGET, 16'h7FFF);
    send_item(OP_SET_TARGET, 16'h8000);
    configure(16'd1, 16'd255);
    send_item(OP_SET_TARGET, 16'hFFFF);  // -255/256 truncates to zero
    configure(16'd1, 16'd0);
    send_item(OP_SET_TARGET, 16'd12345);
    configure(16'd1, 16'd1);
    send_item(OP_SET_TARGET, 16'hFF01);
    send_item(OP_SET_TARGET, 16'hFF00);
    send_item(OP_TICK, 16'h0000);
  endtask

  // Long delay: the step lands exactly on the tick that reaches the delay
  task automatic test_long_step_delay();
    logic [15:0] deg;
    configure(16'd300, 16'd256);
    tx_gaps_en = 1'b0;
    rx_stall_en = 1'b0;
    deg = 16'(pos_q + 1);
    send_item(OP_SET_TARGET, deg);
    repeat (302) send_item(OP_TICK, 16'h0000);
  endtask

  task automatic test_output_backpressure();
    configure(16'd2, 16'd256);
    tx_gaps_en = 1'b0;
    rx_stall_en = 1'b0;
    long_hold_requests = long_hold_requests + 1;
    send_item(OP_SET_TARGET, 16'd5);
    repeat (40) send_item(OP_TICK, 16'(items_sent));
    send_item(OP_SET_TARGET, 16'hFFFD);
    repeat (8) send_item(OP_TICK, 16'hFFFF);
  endtask

  task automatic test_random_moves();
    int delays[7];
    int spds[7];
    int phase_end;
    int r;
    int burst;
    longint span;
    longint need;
    delays = '{0, 1, 2, 3, 0, 4, 5};
    spds   = '{1, 256, 100, 65535, 511, 700, 300};
    for (int ph = 0; ph < 7; ph++) begin
      configure(CFG_W'(delays[ph]), CFG_W'(spds[ph]));
      tx_gaps_en  = (ph % 3 != 2);
      rx_stall_en = (ph % 3 != 1);
      phase_end = items_sent + 220;
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          // move to a reachable target, then usually enough ticks to get there
          send_item(OP_SET_TARGET, 16'($urandom_range(0, 40)) - 16'd20);
          span = longint'(target_q) - longint'(pos_q);
          if (span < 0) span = -span;
          need = span * ((step_delay_q == 0) ? 1 : longint'(step_delay_q));
          if (need > 150 || $urandom_range(0, 4) == 0) burst = $urandom_range(1, 30);
          else burst = int'(need) + $urandom_range(0, 4);
          repeat (burst) send_item(OP_TICK, 16'($urandom));
          if ($urandom_range(0, 3) == 0) send_item(OP_ENERGIZE, 16'($urandom));
        end else if (r < 85) begin
          send_item(OP_SET_TARGET, 16'($urandom));
          repeat ($urandom_range(1, 10)) send_item(OP_TICK, 16'($urandom));
        end else if (r < 93) begin
          send_item(OP_ENERGIZE, 16'($urandom));
        end else begin
          send_item(OP_UNUSED, 16'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_power_on_defaults();
    test_half_step_walk();
    test_angle_conversion();
    test_long_step_delay();
    test_output_backpressure();
    test_random_moves();
    drain_stream();
    repeat (10) @(posedge clk);
    if (err_count == 0 && expected_motion.size() == 0) begin
      $display("PASS stepper_half_step_positioner");
    end else begin
      $display("FAIL stepper_half_step_positioner");
    end
    $finish;
  end

endmodule
`default_nettype wire
